/* rtl/hmac_pkg.sv */
// Package for the HMAC-SHA256 engine: round constants, initial hash values,
// front-to-back command type and the back-end state enum. No dependencies.
package hmac_pkg;

  localparam int BlockBytes = 64;

  typedef logic [31:0] word_t;
  typedef logic [255:0] hash_t;

  // Request from front to back: one byte, a finish marker, or both.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEYIN,
    ST_WAIT,
    ST_PADSEL,
    ST_PAD2,
    ST_OKEY,
    ST_OMSG,
    ST_OUT,
    ST_RUN
  } bk_state_t;

  localparam hash_t ShaIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

/* rtl/hmac_core.sv */
// SHA-256 compression unit: one round per clock, 64 rounds per block.
// Depends on hmac_pkg for round constants.
module hmac_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  hmac_pkg::hash_t h_in,
  input  logic [511:0]   blk,
  output logic           busy,
  output logic           done,
  output hmac_pkg::hash_t h_out
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0]  rnd;
  logic [31:0] s0, s1, wn, e1, ch, a0, mj, t1, t2;

  assign a = v[0]; assign b = v[1]; assign c = v[2]; assign d = v[3];
  assign e = v[4]; assign f = v[5]; assign g = v[6]; assign h = v[7];

  // Round logic and message schedule.
  always_comb begin
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    e1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch = (e & f) ^ (~e & g);
    t1 = h + e1 + ch + hmac_pkg::round_k(rnd) + w[0];
    a0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    mj = (a & b) ^ (a & c) ^ (b & c);
    t2 = a0 + mj;
  end

  // Done pulses for one cycle after the last round.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && (rnd == 6'd63);
    end
  end

  // Round counter, working variables, schedule window and final hash addition.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      rnd  <= '0;
      for (int i = 0; i < 16; i++) w[i] <= blk[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= h_in[255 - 32*i -: 32];
      h_out <= h_in;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      v[7] <= g; v[6] <= f; v[5] <= e; v[4] <= d + t1;
      v[3] <= c; v[2] <= b; v[1] <= a; v[0] <= t1 + t2;
      rnd <= rnd + 6'd1;
      if (rnd == 6'd63) begin
        busy <= 1'b0;
      end
    end else if (done) begin
      for (int i = 0; i < 8; i++) h_out[255 - 32*i -: 32] <= h_out[255 - 32*i -: 32] + v[i];
    end
  end

  // A start is only issued while the unit is free.
  a_start_free: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("compression started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_done_round: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(rnd) == 6'd63) else $error("done before last round");

endmodule

/* rtl/hmac_front.sv */
// Front end: accepts input requests and buffers them in a short queue.
// Depends on hmac_pkg for the request type.
module hmac_front #(
  parameter int Depth = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hmac_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_pop,
  output hmac_pkg::cmd_t q_cmd
);

  localparam int AW = $clog2(Depth);

  hmac_pkg::cmd_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic push, pop;

  assign in_ready = (cnt != (AW+1)'(Depth));
  assign q_valid  = (cnt != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_cmd    = mem[rp];

  // Queue pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + AW'(1);
      if (pop) rp <= rp + AW'(1);
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_cmd;
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(Depth)) else $error("queue overflow");
  a_pop_val: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1) else $error("count slip");

endmodule

/* rtl/hmac_back.sv */
// Back end: builds blocks, sequences inner and outer hashes, emits the tag.
// Depends on hmac_pkg and hmac_core.
module hmac_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [511:0]   key,
  input  logic           q_valid,
  output logic           q_pop,
  input  hmac_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    tag_word,
  output logic [1:0]     word_index,
  output logic           last_word
);

  hmac_pkg::bk_state_t state, state_next, ret, ret_next;
  logic [511:0] blk_reg;
  logic [6:0]   fill;
  logic [63:0]  mbits;
  logic         key_abs;
  hmac_pkg::hash_t chain, inner;
  logic [511:0] cblk;
  logic         cstart, cbusy, cdone;
  hmac_pkg::hash_t cin, cout;
  logic         eom_pend;
  logic [1:0]   widx;

  hmac_core u_core (
    .clk(clk), .rst(rst), .start(cstart), .h_in(cin), .blk(cblk),
    .busy(cbusy), .done(cdone), .h_out(cout)
  );

  logic [511:0] ipad_blk, opad_blk, pad_blk, pad2_blk, omsg_blk;
  logic [5:0]   f6;
  assign f6 = fill[5:0];
  always_comb begin
    ipad_blk = key ^ {64{8'h36}};
    opad_blk = key ^ {64{8'h5c}};
    // Padded block: 0x80 after the stored bytes, then the length if fill < 56.
    for (int i = 0; i < hmac_pkg::BlockBytes; i++) begin
      if (6'(i) < f6) pad_blk[511 - 8*i -: 8] = blk_reg[511 - 8*i -: 8];
      else if (6'(i) == f6) pad_blk[511 - 8*i -: 8] = 8'h80;
      else pad_blk[511 - 8*i -: 8] = 8'h00;
    end
    if (f6 < 6'd56) pad_blk[63:0] = mbits;
    pad2_blk = {448'd0, mbits};
    omsg_blk = {inner, 8'h80, 184'd0, 64'd768};
  end

  logic pad_one;
  assign pad_one = f6 < 6'd56;

  // Sequencer.
  always_comb begin
    state_next = state;
    ret_next   = ret;
    q_pop      = 1'b0;
    cstart     = 1'b0;
    cin        = chain;
    cblk       = blk_reg;
    case (state)
      hmac_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (!key_abs) begin
            cin = hmac_pkg::ShaIv; cblk = ipad_blk; cstart = 1'b1;
            state_next = hmac_pkg::ST_WAIT; ret_next = hmac_pkg::ST_IDLE;
          end else begin
            q_pop = 1'b1;
            state_next = hmac_pkg::ST_KEYIN;
          end
        end
      end
      hmac_pkg::ST_KEYIN: begin
        // Byte written last cycle; compress a full block, else check end.
        if (fill == 7'd64) begin
          cstart = 1'b1; state_next = hmac_pkg::ST_WAIT;
          ret_next = eom_pend ? hmac_pkg::ST_PADSEL : hmac_pkg::ST_IDLE;
        end else if (eom_pend) state_next = hmac_pkg::ST_PADSEL;
        else state_next = hmac_pkg::ST_IDLE;
      end
      hmac_pkg::ST_PADSEL: begin
        cblk = pad_blk; cstart = 1'b1; state_next = hmac_pkg::ST_WAIT;
        ret_next = pad_one ? hmac_pkg::ST_OKEY : hmac_pkg::ST_PAD2;
      end
      hmac_pkg::ST_PAD2: begin
        cblk = pad2_blk; cstart = 1'b1; state_next = hmac_pkg::ST_WAIT;
        ret_next = hmac_pkg::ST_OKEY;
      end
      hmac_pkg::ST_OKEY: begin
        cin = hmac_pkg::ShaIv; cblk = opad_blk; cstart = 1'b1;
        state_next = hmac_pkg::ST_WAIT; ret_next = hmac_pkg::ST_OMSG;
      end
      hmac_pkg::ST_OMSG: begin
        cblk = omsg_blk; cstart = 1'b1;
        state_next = hmac_pkg::ST_WAIT; ret_next = hmac_pkg::ST_OUT;
      end
      hmac_pkg::ST_WAIT: begin
        if (cbusy) state_next = hmac_pkg::ST_RUN;
      end
      hmac_pkg::ST_RUN: begin
        if (!cbusy && !cdone) state_next = ret;
      end
      hmac_pkg::ST_OUT: begin
        if (out_ready && widx == 2'd3) state_next = hmac_pkg::ST_IDLE;
      end
      default: state_next = hmac_pkg::ST_IDLE;
    endcase
  end

  // The core result settles in the cycle after done; ST_RUN waits for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmac_pkg::ST_IDLE; ret <= hmac_pkg::ST_IDLE;
      fill <= '0; mbits <= '0; key_abs <= 1'b0; chain <= hmac_pkg::ShaIv;
      eom_pend <= 1'b0; widx <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (state == hmac_pkg::ST_RUN && !cbusy && !cdone) begin
        chain <= cout;
        if (!key_abs) begin
          key_abs <= 1'b1; fill <= '0; mbits <= 64'd512;
        end
        if (fill == 7'd64) fill <= '0;
      end
      if (q_pop) begin
        eom_pend <= q_cmd.eom;
        if (q_cmd.has_byte) begin
          fill <= fill + 7'd1;
          mbits <= (mbits > 64'hFFFF_FFFF_FFFF_FFF7) ? '1 : mbits + 64'd8;
        end
      end
      if (state == hmac_pkg::ST_OUT && out_ready) begin
        widx <= widx + 2'd1;
        if (widx == 2'd3) begin
          chain <= hmac_pkg::ShaIv; fill <= '0; mbits <= '0; key_abs <= 1'b0;
          eom_pend <= 1'b0;
        end
      end
    end
  end

  // Inner digest is captured from chain when the outer key block is issued (ST_OKEY).
  always_ff @(posedge clk) begin
    if (state == hmac_pkg::ST_OKEY) inner <= chain;
  end

  // Block register: byte n sits in bits 511-8n downwards, and 511-8n is {~n, 3'b111}.
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.has_byte) blk_reg[{~f6, 3'b111} -: 8] <= q_cmd.data;
  end

  assign out_valid  = (state == hmac_pkg::ST_OUT);
  assign tag_word   = chain[255 - 64*widx -: 64];
  assign word_index = widx;
  assign last_word  = (widx == 2'd3);

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !cbusy) else $error("output while hashing");
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= 7'd64)
    else $error("fill out of range");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> state == hmac_pkg::ST_IDLE)
    else $error("no return to idle after tag");

endmodule

/* rtl/hmac_sha256_engine.sv */
// HMAC-SHA256 engine top level: APB key registers, front queue, back sequencer.
// Depends on hmac_pkg, hmac_front, hmac_back, hmac_core.
//
//  channel  | dir | contents
//  s_axis   | in  | tdata = data_byte, tuser = has_byte, tlast = end_of_message
//  m_axis   | out | tdata = tag_word, tuser = word_index, tlast = last_word
//  apb      | cfg | key_word0..7 at byte address 8*i, 64-bit data
//
// A byte request is handled by the pop and then the block-full check.
// Each block compression runs from the issuing state through the issue, the 64 rounds,
// the done pulse and the settling of the result, then on to the next state.
// The first request of a message adds the key block; a byte that fills a block adds
// one more. A final request adds three compressions (four when 56 or more bytes are
// stored in the block), then the four tag words. Reset is synchronous.
// The queue accepts requests while the back end hashes; tag output stalls on m_axis_tready.
module hmac_sha256_engine #(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] tag_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_r [8];
  logic [511:0] key;
  hmac_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  assign pready = 1'b1;

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
    end else if (psel && penable && pwrite) begin
      key_r[paddr[5:3]] <= pwdata;
    end
  end

  assign prdata = key_r[paddr[5:3]];
  always_comb begin
    for (int i = 0; i < 8; i++) key[511 - 64*i -: 64] = key_r[i];
  end

  assign in_cmd = '{data: s_axis_tdata, has_byte: s_axis_tuser, eom: s_axis_tlast};

  hmac_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  hmac_back u_back (
    .clk(clk), .rst(rst), .key(key), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .tag_word(m_axis_tdata),
    .word_index(m_axis_tuser), .last_word(m_axis_tlast)
  );

endmodule
